/* hdl/swm_pkg.sv */
// Shared types and constants for the sliding window maximum block.
// Used by the controller, the datapath and the top level; depends on nothing.
package swm_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 32;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0] CFG_LEN_RESET = 7'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     restart;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] window_max;
    logic [POS_W-1:0]         window_end;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic rd_front;
    logic rd_back;
    logic drop_head;
    logic drop_tail;
    logic append;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cand_empty;
    logic front_expired;
    logic back_smaller;
    logic window_full;
    logic out_free;
  } status_t;

endpackage

/* hdl/swm_ctrl.sv */
// Sequencer for the sliding window maximum: walks one sample through front
// expiry, back pops, append and result load. Depends on swm_pkg.
module swm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  swm_pkg::status_t status,
  output swm_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_FRONT_RD  = 3'd1;
  localparam logic [2:0] ST_FRONT_CHK = 3'd2;
  localparam logic [2:0] ST_BACK_RD   = 3'd3;
  localparam logic [2:0] ST_BACK_CHK  = 3'd4;
  localparam logic [2:0] ST_APPEND    = 3'd5;
  localparam logic [2:0] ST_OUT_RD    = 3'd6;
  localparam logic [2:0] ST_OUT_LD    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign sample_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid && sample_ready) begin
          cmd.take   = 1'b1;
          state_next = ST_FRONT_RD;
        end
      end
      ST_FRONT_RD: begin
        if (status.cand_empty) begin
          state_next = ST_APPEND;
        end else begin
          cmd.rd_front = 1'b1;
          state_next   = ST_FRONT_CHK;
        end
      end
      ST_FRONT_CHK: begin
        // drop one expired candidate per pass, then look again
        if (status.front_expired) begin
          cmd.drop_head = 1'b1;
          state_next    = ST_FRONT_RD;
        end else begin
          state_next = ST_BACK_RD;
        end
      end
      ST_BACK_RD: begin
        if (status.cand_empty) begin
          state_next = ST_APPEND;
        end else begin
          cmd.rd_back = 1'b1;
          state_next  = ST_BACK_CHK;
        end
      end
      ST_BACK_CHK: begin
        if (status.back_smaller) begin
          cmd.drop_tail = 1'b1;
          state_next    = ST_BACK_RD;
        end else begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        if (status.window_full) begin
          cmd.rd_front = 1'b1;
          state_next   = ST_OUT_LD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT_LD: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/swm_dp.sv */
// Datapath for the sliding window maximum: candidate ring memory, pointers,
// position and fill counters, config register and output register. Depends on swm_pkg.
module swm_dp #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_data,
  input  swm_pkg::sample_t              sample_data,
  output logic                          result_valid,
  input  logic                          result_ready,
  output swm_pkg::result_t              result_data,
  input  swm_pkg::cmd_t                 cmd,
  output swm_pkg::status_t              status
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = AW + 2;

  typedef struct packed {
    logic signed [swm_pkg::DATA_W-1:0] val;
    logic [swm_pkg::POS_W-1:0]         pos;
  } entry_t;

  entry_t mem [MAX_WINDOW];
  entry_t rd_data;

  logic [swm_pkg::CFG_W-1:0]        cfg_len;
  logic [AW-1:0]                    head;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    seen;
  logic [swm_pkg::POS_W-1:0]        pos;
  logic [swm_pkg::POS_W-1:0]        cur_pos;
  logic signed [swm_pkg::DATA_W-1:0] cur_sample;

  logic [31:0]   len_ext;
  logic [31:0]   keff;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] free_addr;
  logic [AW-1:0] rd_addr;
  logic          cand_full;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    if (s >= SW'(MAX_WINDOW)) begin
      return AW'(s - SW'(MAX_WINDOW));
    end
    return AW'(s);
  endfunction

  // window length: zero acts as one, saturate at the ring depth
  assign len_ext = 32'(cfg_len);
  always_comb begin
    if (len_ext == 32'd0) begin
      keff = 32'd1;
    end else if (len_ext > 32'(MAX_WINDOW)) begin
      keff = 32'(MAX_WINDOW);
    end else begin
      keff = len_ext;
    end
  end

  assign tail_addr = wrap(SW'(head) + SW'(count) - SW'(1));
  assign free_addr = wrap(SW'(head) + SW'(count));
  assign rd_addr   = cmd.rd_back ? tail_addr : head;
  assign cand_full = (count == CW'(MAX_WINDOW));

  assign status.cand_empty    = (count == '0);
  assign status.front_expired = ((cur_pos - rd_data.pos) >= keff);
  assign status.back_smaller  = ($signed(rd_data.val) < cur_sample);
  assign status.window_full   = (32'(seen) >= keff);
  assign status.out_free      = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.append && !cand_full) begin
      mem[free_addr] <= '{val: cur_sample, pos: cur_pos};
    end
    if (cmd.rd_front || cmd.rd_back) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= swm_pkg::CFG_LEN_RESET;
      head    <= '0;
      count   <= '0;
      seen    <= '0;
      pos     <= '0;
    end else begin
      if (cfg_valid) begin
        cfg_len <= cfg_data;
      end
      if (cmd.take && sample_data.restart) begin
        head  <= '0;
        count <= '0;
        seen  <= '0;
        pos   <= '0;
      end
      if (cmd.drop_head) begin
        head  <= (head == AW'(MAX_WINDOW - 1)) ? '0 : head + AW'(1);
        count <= count - CW'(1);
      end
      if (cmd.drop_tail) begin
        count <= count - CW'(1);
      end
      if (cmd.append) begin
        if (!cand_full) begin
          count <= count + CW'(1);
        end
        if (seen != CW'(MAX_WINDOW)) begin
          seen <= seen + CW'(1);
        end
        pos <= cur_pos + swm_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_sample <= sample_data.sample;
      cur_pos    <= sample_data.restart ? '0 : pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_data.window_max <= rd_data.val;
      result_data.window_end <= cur_pos;
    end
  end

endmodule

/* hdl/sliding_window_maximum.sv */
// Sliding window maximum over a stream of signed samples.
// Channels: sample (valid/ready, sample_t payload with a restart flag),
// result (valid/ready, result_t payload), cfg (valid/ready, window length).
// A restart sample clears the candidate deque and takes position 0.
// One sample is processed at a time; sample_ready is high only while idle
// and out of reset.
// Per sample: after the accept, expired candidates are dropped from the front and
// smaller candidates popped from the back, one per pass, until a probe finds none or
// the deque empty; the sample is then appended and, once the window is full, the
// result is loaded. Each deque probe is one read of the candidate ring memory and
// one compare step.
// A result appears once the samples since restart reach the window length;
// earlier samples produce nothing.
// The result sits in an output register, so the next sample is taken while
// it waits; a stalled receiver only holds the block at its final load step.
// Reset clears the deque, position and fill counts and sets the window
// length to 3; the ring memory itself is not cleared and needs no sweep.
// cfg_ready is high outside reset; write the length only while idle.
module sliding_window_maximum #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0] cfg_data,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  swm_pkg::sample_t          sample_data,
  output logic                      result_valid,
  input  logic                      result_ready,
  output swm_pkg::result_t          result_data
);

  swm_pkg::cmd_t    cmd;
  swm_pkg::status_t status;

  assign cfg_ready = !rst;

  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  swm_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

/* hdl/swm_checker.sv */
// Port-level checks for the sliding window maximum, bound to the top level.
// Depends on swm_pkg for the payload types.
module swm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic                      sample_valid,
  input logic                      sample_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input swm_pkg::result_t          result_data
);

  // a stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // one sample at a time: ready drops after each transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while busy");

  // a new result is only loaded while a sample is in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(sample_ready))
    else $error("result appeared while idle");

  // configuration is always accepted
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind sliding_window_maximum swm_checker u_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_maximum: directed and random sample streams.
// Holds a scoreboard class that predicts each window maximum; depends on swm_pkg.
module testbench;

  // Settle time after draining: covers the longest sample, with its expiry checks, back pops,
  // append and result load.
  localparam int SETTLE_CYCLES = 300;
  localparam int DEPTH         = 64;
  localparam int PHASE_ITEMS   = 100;

  localparam logic signed [swm_pkg::DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [swm_pkg::DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  typedef enum int unsigned {
    SHAPE_NOISE,
    SHAPE_NARROW,
    SHAPE_FALLING,
    SHAPE_RISING,
    SHAPE_EXTREME
  } shape_e;

  class window_max_scoreboard;
    logic signed [swm_pkg::DATA_W-1:0] cand_val [DEPTH];
    logic [swm_pkg::POS_W-1:0]         cand_pos [DEPTH];
    int unsigned                       head;
    int unsigned                       count;
    logic [swm_pkg::POS_W-1:0]         next_pos;
    int unsigned                       seen;
    logic [swm_pkg::CFG_W-1:0]         win_len;
    swm_pkg::result_t                  pending_q [$];
    int unsigned                       errors;

    function new();
      head     = 0;
      count    = 0;
      next_pos = '0;
      seen     = 0;
      win_len  = swm_pkg::CFG_LEN_RESET;
      errors   = 0;
    endfunction

    function void set_window(input logic [swm_pkg::CFG_W-1:0] len);
      win_len = len;
    endfunction

    function bit idle();
      return pending_q.size() == 0;
    endfunction

    // Advance the deque by one accepted sample and queue the maximum it yields.
    function void note_sample(input swm_pkg::sample_t s);
      int unsigned                       k;
      logic [swm_pkg::POS_W-1:0]         pos;
      logic [swm_pkg::POS_W-1:0]         age;
      logic signed [swm_pkg::DATA_W-1:0] v;
      swm_pkg::result_t                  r;
      v = s.sample;
      k = (win_len == 0) ? 1 : (win_len > DEPTH) ? DEPTH : win_len;
      if (s.restart) begin
        head     = 0;
        count    = 0;
        next_pos = '0;
        seen     = 0;
      end
      pos = next_pos;
      // drop candidates that have aged out, modulo the position width
      while (count > 0) begin
        age = pos - cand_pos[head];
        if (age < k) break;
        head  = (head + 1) % DEPTH;
        count = count - 1;
      end
      // drop strictly smaller candidates from the back; equal ones stay
      while (count > 0 && cand_val[(head + count - 1) % DEPTH] < v) count = count - 1;
      if (count < DEPTH) begin
        cand_val[(head + count) % DEPTH] = v;
        cand_pos[(head + count) % DEPTH] = pos;
        count = count + 1;
      end
      next_pos = pos + 1;
      if (seen < DEPTH) seen = seen + 1;
      if (seen >= k) begin
        r.window_max = cand_val[head];
        r.window_end = pos;
        pending_q = {pending_q, r};
      end
    endfunction

    function void check_result(input swm_pkg::result_t r);
      swm_pkg::result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual max=%h end=%h",
                 $time, r.window_max, r.window_end);
        errors++;
        return;
      end
      want = pending_q[0];
      pending_q.delete(0);
      if (r.window_max !== want.window_max) begin
        $display("%0t: window_max mismatch, expected %h, actual %h",
                 $time, want.window_max, r.window_max);
        errors++;
      end
      if (r.window_end !== want.window_end) begin
        $display("%0t: window_end mismatch, expected %h, actual %h",
                 $time, want.window_end, r.window_end);
        errors++;
      end
    endfunction
  endclass

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [swm_pkg::CFG_W-1:0] cfg_data     = '0;
  logic                      sample_valid = 1'b0;
  logic                      sample_ready;
  swm_pkg::sample_t          sample_data  = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  swm_pkg::result_t          result_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  window_max_scoreboard sb = new();

  sliding_window_maximum i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** sliding_window_maximum: FAILED **");
    $finish;
  end

  // Receiver: a requested hold-off wins over the random stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_window(cfg_data);
      if (sample_valid && sample_ready) sb.note_sample(sample_data);
      if (result_valid && result_ready) sb.check_result(result_data);
    end
  end

  function automatic swm_pkg::sample_t mk(input logic signed [swm_pkg::DATA_W-1:0] v,
                                          input logic rs);
    swm_pkg::sample_t s;
    s.sample  = v;
    s.restart = rs;
    return s;
  endfunction

  function automatic logic signed [swm_pkg::DATA_W-1:0] pick_value(
      input shape_e shape, input logic signed [swm_pkg::DATA_W-1:0] last);
    case (shape)
      SHAPE_NOISE:   return $urandom;
      SHAPE_NARROW:  return $signed($urandom_range(6)) - 3;
      SHAPE_FALLING: return last - $urandom_range(3);
      SHAPE_RISING:  return last + $urandom_range(3);
      default: begin
        case ($urandom_range(3))
          0:       return MOST_NEG;
          1:       return MOST_POS;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Call it right after posedge clk; valid stays high into the following transaction when no gap falls.
  task automatic send_sample(input swm_pkg::sample_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (!sb.idle()) @(posedge clk);
  endtask

  // A sample may produce nothing, so let the last one finish before writing.
  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] len);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [swm_pkg::CFG_W-1:0]         phase_len [16];
    shape_e                            shape;
    int unsigned                       run_left;
    logic signed [swm_pkg::DATA_W-1:0] last;
    logic                              rs;

    phase_len = '{7'd1, 7'd64, 7'd127, 7'd2, 7'd65, 7'd7, 7'd0, 7'd33,
                  7'd64, 7'd3, 7'd100, 7'd16, 7'd1, 7'd48, 7'd5, 7'd64};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset length of three: extremes, equal maxima and a falling run after restart.
    send_sample(mk(MOST_NEG, 1'b1));
    send_sample(mk(MOST_POS, 1'b0));
    send_sample(mk(MOST_NEG, 1'b0));
    send_sample(mk(0, 1'b0));
    send_sample(mk(-1, 1'b0));
    send_sample(mk(5, 1'b0));
    send_sample(mk(5, 1'b0));
    send_sample(mk(5, 1'b0));
    send_sample(mk(1, 1'b0));
    send_sample(mk(MOST_POS, 1'b0));
    send_sample(mk(MOST_POS, 1'b0));
    send_sample(mk(-1, 1'b1));
    send_sample(mk(-2, 1'b0));
    send_sample(mk(-3, 1'b0));
    send_sample(mk(-4, 1'b0));
    send_sample(mk(-4, 1'b0));
    // zero length acts as one
    write_window(7'd0);
    send_sample(mk(7, 1'b0));
    send_sample(mk(MOST_NEG, 1'b0));
    send_sample(mk(MOST_POS, 1'b0));
    // grow twice, without a restart
    write_window(7'd2);
    send_sample(mk(3, 1'b0));
    send_sample(mk(9, 1'b0));
    send_sample(mk(1, 1'b0));
    write_window(7'd5);
    send_sample(mk(2, 1'b0));
    send_sample(mk(8, 1'b0));
    send_sample(mk(8, 1'b0));

    last     = 0;
    run_left = 0;
    shape    = SHAPE_NOISE;
    for (int p = 0; p < 16; p++) begin
      write_window(phase_len[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == 30) hold_left = 600;
        if (p == 6 && i == 50) wait_drained();
        if (run_left == 0) begin
          shape    = shape_e'($urandom_range(4));
          run_left = $urandom_range(40, 4);
        end
        run_left = run_left - 1;
        last = pick_value(shape, last);
        // restart at some phase starts and now and then at random; otherwise a length change lands mid-stream
        rs = (i == 0 && p % 3 == 0) || ($urandom_range(63) == 0);
        send_sample(mk(last, rs));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.idle()) begin
      $display("** sliding_window_maximum: PASSED **");
    end else begin
      $display("** sliding_window_maximum: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/swm_pkg.sv
hdl/swm_ctrl.sv
hdl/swm_dp.sv
hdl/sliding_window_maximum.sv
hdl/swm_checker.sv
dv/testbench.sv
